FILE: rtl/thlri_pkg.sv
`default_nettype none
package thlri_pkg;

	localparam int unsigned LIST_DEPTH_DEF = 64;
	localparam int unsigned LABEL_COUNT_DEF = 16;
	localparam int unsigned VERTEX_BITS_DEF = 20;

	localparam int unsigned MODE_W = 2;
	localparam int unsigned VERTEX_W = 20;
	localparam int unsigned MASK_W = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_INS_OUT = 2'd1,
		MODE_INS_IN = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef struct packed {
		logic eq;
		logic lt;
		logic a_in_c;
		logic b_in_c;
		logic c_in_a;
	} cmp_res_t;

endpackage
`default_nettype wire

FILE: rtl/thlri_req_if.sv
`default_nettype none
interface thlri_req_if;
	logic                           valid;
	logic                           ready;
	logic [thlri_pkg::MODE_W-1:0]   mode;
	logic [thlri_pkg::VERTEX_W-1:0] vertex_a;
	logic [thlri_pkg::VERTEX_W-1:0] vertex_b;
	logic [thlri_pkg::MASK_W-1:0]   label_mask;

	modport source (output valid, mode, vertex_a, vertex_b, label_mask, input ready);
	modport sink (input valid, mode, vertex_a, vertex_b, label_mask, output ready);
endinterface
`default_nettype wire

FILE: rtl/thlri_rsp_if.sv
`default_nettype none
interface thlri_rsp_if;
	logic valid;
	logic ready;
	logic answer;
	logic list_full;

	modport source (output valid, answer, list_full, input ready);
	modport sink (input valid, answer, list_full, output ready);
endinterface
`default_nettype wire

FILE: rtl/thlri_list_mem.sv
`default_nettype none
module thlri_list_mem #(
	parameter int unsigned DEPTH = thlri_pkg::LIST_DEPTH_DEF,
	parameter int unsigned WIDTH = thlri_pkg::VERTEX_BITS_DEF + thlri_pkg::LABEL_COUNT_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/thlri_cmp.sv
`default_nettype none
module thlri_cmp #(
	parameter int unsigned VERTEX_BITS = thlri_pkg::VERTEX_BITS_DEF,
	parameter int unsigned LABEL_COUNT = thlri_pkg::LABEL_COUNT_DEF
) (
	input  wire logic [VERTEX_BITS-1:0] hub_a,
	input  wire logic [VERTEX_BITS-1:0] hub_b,
	input  wire logic [LABEL_COUNT-1:0] mask_a,
	input  wire logic [LABEL_COUNT-1:0] mask_b,
	input  wire logic [LABEL_COUNT-1:0] mask_c,
	output thlri_pkg::cmp_res_t         res
);
	always_comb begin
		res.eq = hub_a == hub_b;
		res.lt = hub_a < hub_b;
		res.a_in_c = (mask_a & ~mask_c) == '0;
		res.b_in_c = (mask_b & ~mask_c) == '0;
		res.c_in_a = (mask_c & ~mask_a) == '0;
	end
endmodule
`default_nettype wire

FILE: rtl/two_hop_label_reach_index.sv
// Label-constrained two-hop reachability index holding one out hub list and one
// in hub list, each sorted by hub and kept free of dominated entries. One item is
// taken at a time; the block is busy until its result has been taken. Each list
// entry visit has an address phase and a compare phase, because the list memories
// have registered reads. A clear empties both lists by resetting their counts. An
// insert scans its list for dominance, compacts it when entries are replaced, and
// shifts larger entries up to make room. A query checks both lists for a direct
// hub, then runs a sorted merge of the two lists to find a shared hub.
// All of this runs through one compare unit driven by a small sequencer.
`default_nettype none
module two_hop_label_reach_index #(
	parameter int unsigned LIST_DEPTH = thlri_pkg::LIST_DEPTH_DEF,
	parameter int unsigned LABEL_COUNT = thlri_pkg::LABEL_COUNT_DEF,
	parameter int unsigned VERTEX_BITS = thlri_pkg::VERTEX_BITS_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	thlri_req_if.sink    req,
	thlri_rsp_if.source  rsp
);
	localparam int unsigned AW = $clog2(LIST_DEPTH);
	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
	localparam int unsigned EW = VERTEX_BITS + LABEL_COUNT;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SCAN  = 9'b000000010,
		S_COMP  = 9'b000000100,
		S_SHIFT = 9'b000001000,
		S_PUT   = 9'b000010000,
		S_QIN   = 9'b000100000,
		S_QOUT  = 9'b001000000,
		S_MERGE = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t                 state_q;
	logic                   ph_q;
	thlri_pkg::mode_t       mode_q;
	logic [VERTEX_BITS-1:0] va_q, vb_q;
	logic [LABEL_COUNT-1:0] m_q;
	logic [CW-1:0]          cnt_out_q, cnt_in_q, i_q, j_q, k_q;
	logic                   sup_q, ans_q, full_q;

	logic [63:0]            va_ext, vb_ext, m_ext;
	logic                   sel_in;
	logic [CW-1:0]          n_sel, im1;
	logic [AW-1:0]          o_raddr, i_raddr, waddr;
	logic [EW-1:0]          o_rdata, i_rdata, cur, wdata;
	logic                   wr_en;
	logic [VERTEX_BITS-1:0] hub_b;
	thlri_pkg::cmp_res_t    cr;

	assign va_ext = 64'(req.vertex_a);
	assign vb_ext = 64'(req.vertex_b);
	assign m_ext = 64'(req.label_mask);
	assign sel_in = mode_q == thlri_pkg::MODE_INS_IN;
	assign n_sel = sel_in ? cnt_in_q : cnt_out_q;
	assign im1 = i_q - CW'(1);

	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = state_q == S_DONE;
	assign rsp.answer = ans_q;
	assign rsp.list_full = full_q;

	always_comb begin
		o_raddr = i_q[AW-1:0];
		i_raddr = (state_q == S_MERGE) ? j_q[AW-1:0] : i_q[AW-1:0];
		if (state_q == S_SHIFT) begin
			o_raddr = im1[AW-1:0];
			i_raddr = im1[AW-1:0];
		end
		cur = (state_q == S_QIN || sel_in) ? i_rdata : o_rdata;
		case (state_q)
			S_QIN:   hub_b = va_q;
			S_MERGE: hub_b = i_rdata[EW-1:LABEL_COUNT];
			default: hub_b = vb_q;
		endcase
		wr_en = 1'b0;
		waddr = i_q[AW-1:0];
		wdata = cur;
		case (state_q)
			S_COMP: begin
				wr_en = ph_q && !(cr.eq && cr.c_in_a);
				waddr = k_q[AW-1:0];
			end
			S_SHIFT: wr_en = ph_q && !cr.eq && !cr.lt;
			S_PUT: begin
				wr_en = 1'b1;
				wdata = {vb_q, m_q};
			end
			default: wr_en = 1'b0;
		endcase
	end

	thlri_list_mem #(.DEPTH(LIST_DEPTH), .WIDTH(EW)) u_out_mem (
		.clk(clk), .we(wr_en && !sel_in), .waddr(waddr), .wdata(wdata),
		.raddr(o_raddr), .rdata(o_rdata)
	);

	thlri_list_mem #(.DEPTH(LIST_DEPTH), .WIDTH(EW)) u_in_mem (
		.clk(clk), .we(wr_en && sel_in), .waddr(waddr), .wdata(wdata),
		.raddr(i_raddr), .rdata(i_rdata)
	);

	thlri_cmp #(.VERTEX_BITS(VERTEX_BITS), .LABEL_COUNT(LABEL_COUNT)) u_cmp (
		.hub_a(cur[EW-1:LABEL_COUNT]), .hub_b(hub_b),
		.mask_a(cur[LABEL_COUNT-1:0]), .mask_b(i_rdata[LABEL_COUNT-1:0]),
		.mask_c(m_q), .res(cr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q <= 1'b0;
			cnt_out_q <= '0;
			cnt_in_q <= '0;
			mode_q <= thlri_pkg::MODE_CLEAR;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			sup_q <= 1'b0;
			ans_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						mode_q <= thlri_pkg::mode_t'(req.mode);
						va_q <= va_ext[VERTEX_BITS-1:0];
						vb_q <= vb_ext[VERTEX_BITS-1:0];
						m_q <= m_ext[LABEL_COUNT-1:0];
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
						sup_q <= 1'b0;
						ph_q <= 1'b0;
						ans_q <= 1'b0;
						full_q <= 1'b0;
						case (thlri_pkg::mode_t'(req.mode))
							thlri_pkg::MODE_CLEAR: begin
								cnt_out_q <= '0;
								cnt_in_q <= '0;
								ans_q <= 1'b1;
								state_q <= S_DONE;
							end
							thlri_pkg::MODE_QUERY: state_q <= S_QIN;
							default: begin
								if (va_ext[VERTEX_BITS-1:0] == vb_ext[VERTEX_BITS-1:0]) begin
									ans_q <= 1'b1;
									state_q <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (!ph_q) begin
						if (i_q == n_sel) begin
							if (sup_q) begin
								i_q <= '0;
								state_q <= S_COMP;
							end else if (n_sel == CW'(LIST_DEPTH)) begin
								full_q <= 1'b1;
								state_q <= S_DONE;
							end else begin
								k_q <= n_sel;
								state_q <= S_SHIFT;
							end
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						i_q <= i_q + CW'(1);
						if (cr.eq && cr.a_in_c) begin
							state_q <= S_DONE;
						end else if (cr.eq && cr.c_in_a) begin
							sup_q <= 1'b1;
						end
					end
				end
				S_COMP: begin
					if (!ph_q) begin
						if (i_q == n_sel) begin
							i_q <= k_q;
							state_q <= S_SHIFT;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						i_q <= i_q + CW'(1);
						if (!(cr.eq && cr.c_in_a)) begin
							k_q <= k_q + CW'(1);
						end
					end
				end
				S_SHIFT: begin
					if (!ph_q) begin
						if (i_q == '0) begin
							state_q <= S_PUT;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						if (!cr.eq && !cr.lt) begin
							i_q <= im1;
						end else begin
							state_q <= S_PUT;
						end
					end
				end
				S_PUT: begin
					if (sel_in) begin
						cnt_in_q <= k_q + CW'(1);
					end else begin
						cnt_out_q <= k_q + CW'(1);
					end
					ans_q <= 1'b1;
					state_q <= S_DONE;
				end
				S_QIN: begin
					if (!ph_q) begin
						if (i_q == cnt_in_q) begin
							i_q <= '0;
							state_q <= S_QOUT;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						i_q <= i_q + CW'(1);
						if (cr.eq && cr.a_in_c) begin
							ans_q <= 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_QOUT: begin
					if (!ph_q) begin
						if (i_q == cnt_out_q) begin
							i_q <= '0;
							j_q <= '0;
							state_q <= S_MERGE;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						i_q <= i_q + CW'(1);
						if (cr.eq && cr.a_in_c) begin
							ans_q <= 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_MERGE: begin
					if (!ph_q) begin
						if (i_q == cnt_out_q || j_q == cnt_in_q) begin
							state_q <= S_DONE;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						if (!cr.a_in_c) begin
							i_q <= i_q + CW'(1);
						end else if (!cr.b_in_c) begin
							j_q <= j_q + CW'(1);
						end else if (cr.eq) begin
							ans_q <= 1'b1;
							state_q <= S_DONE;
						end else if (cr.lt) begin
							i_q <= i_q + CW'(1);
						end else begin
							j_q <= j_q + CW'(1);
						end
					end
				end
				S_DONE: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/thlri_checker.sv
`default_nettype none
module thlri_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic answer,
	input wire logic list_full
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("block took a new item right after accepting one");

	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("block ready while a result is pending");

	a_full_not_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && list_full |-> !answer)
		else $error("dropped insert reported as accepted");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(answer) && $stable(list_full))
		else $error("stalled result changed");
endmodule

bind two_hop_label_reach_index thlri_checker u_thlri_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.answer(rsp.answer), .list_full(rsp.list_full)
);
`default_nettype wire
